@@ design/sparse_column_select_remap_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sparse column select and remap unit
// Shared concurrent-check shorthands, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COLUMN_SELECT_REMAP_UNIT_ASSERT_SVH
`define SPARSE_COLUMN_SELECT_REMAP_UNIT_ASSERT_SVH

// condition must never hold
`define SCSR_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("scsr check failed: forbidden condition");

// antecedent in one cycle implies consequent in the next
`define SCSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scsr check failed: next-cycle implication");

`endif

@@ design/scsr_pkg.sv @@
// ----------------------------------------------------------------------------
// scsr_pkg
// Shared constants, item codes and interface structs of the sparse column
// select and remap unit.
// ----------------------------------------------------------------------------
package scsr_pkg;

	// map store geometry
	parameter int MAP_DEPTH = 4096;
	parameter int ADDR_W    = $clog2(MAP_DEPTH);
	// carried value bits (low bits of the element word)
	parameter int VALUE_W   = 64;
	// job tag kept with each map entry
	parameter int EPOCH_W   = 8;

	parameter int COL_W     = 32;
	parameter int POS_W     = 16;
	parameter int CNT_W     = 32;

	parameter logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
	parameter logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
	parameter logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	parameter logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

	// input word kinds
	typedef enum logic [1:0] {
		KIND_MAP   = 2'd0,
		KIND_ELEM  = 2'd1,
		KIND_ROW   = 2'd2,
		KIND_START = 2'd3
	} kind_t;

	// result word kinds
	parameter logic OUT_ELEM = 1'b0;
	parameter logic OUT_ROW  = 1'b1;

	// register indexes
	parameter logic REG_WINDOW_FIRST = 1'b0;
	parameter logic REG_WINDOW_LAST  = 1'b1;

	// one map entry: job tag plus new column
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [POS_W-1:0]   target;
	} map_entry_t;

	parameter int ENTRY_W = $bits(map_entry_t);

	// request from the pipeline to the map store
	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic              start;
		logic              slot_ok;
		logic [ADDR_W-1:0] slot;
		logic [POS_W-1:0]  target;
	} map_req_t;

	// lookup answer and store status
	typedef struct packed {
		logic             busy;
		logic             hit;
		logic [POS_W-1:0] target;
	} map_rsp_t;

endpackage

@@ design/scsr_ram.sv @@
// ----------------------------------------------------------------------------
// scsr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module scsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/scsr_map.sv @@
// ----------------------------------------------------------------------------
// scsr_map
// Column map store. Each entry holds a new column and the job tag it was
// written under; an entry counts as mapped only when its tag matches the
// current job. A sweep writes every entry to the null tag after reset and
// whenever the job tag wraps.
// ----------------------------------------------------------------------------
`include "sparse_column_select_remap_unit_assert.svh"

module scsr_map (
	input  logic              clk,
	input  logic              arst_n,
	input  scsr_pkg::map_req_t req,
	output scsr_pkg::map_rsp_t rsp
);

	logic [scsr_pkg::EPOCH_W-1:0] epoch_q;
	logic                         clr_busy_q;
	logic [scsr_pkg::ADDR_W-1:0]  clr_addr_q;
	logic [scsr_pkg::EPOCH_W-1:0] epoch_s1;
	logic                         slot_ok_s1;

	logic                         ram_we;
	logic [scsr_pkg::ADDR_W-1:0]  ram_waddr;
	scsr_pkg::map_entry_t         ram_wdata;
	scsr_pkg::map_entry_t         ram_rdata;
	logic [scsr_pkg::ENTRY_W-1:0] ram_rdata_raw;

	// job tag and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q    <= scsr_pkg::EPOCH_FIRST;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == scsr_pkg::ADDR_W'(scsr_pkg::MAP_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + scsr_pkg::ADDR_W'(1);
		end else if (req.start) begin
			if (epoch_q == scsr_pkg::EPOCH_MAX) begin
				// tag space used up: wipe all tags, restart at first tag
				epoch_q    <= scsr_pkg::EPOCH_FIRST;
				clr_busy_q <= 1'b1;
				clr_addr_q <= '0;
			end else begin
				epoch_q <= epoch_q + scsr_pkg::EPOCH_W'(1);
			end
		end
	end

	// lookup context, held while the reader stalls
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			epoch_s1   <= epoch_q;
			slot_ok_s1 <= req.slot_ok;
		end
	end

	// write port: sweep or map load
	always_comb begin
		ram_we    = clr_busy_q | (req.wr_en & req.slot_ok);
		ram_waddr = clr_busy_q ? clr_addr_q : req.slot;
		ram_wdata.epoch  = clr_busy_q ? scsr_pkg::EPOCH_NONE : epoch_q;
		ram_wdata.target = req.target;
	end

	scsr_ram #(
		.WIDTH(scsr_pkg::ENTRY_W),
		.DEPTH(scsr_pkg::MAP_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (req.rd_en),
		.raddr(req.slot),
		.rdata(ram_rdata_raw)
	);

	assign ram_rdata = scsr_pkg::map_entry_t'(ram_rdata_raw);

	// hit: in range and written during the current job
	always_comb begin
		rsp.busy   = clr_busy_q;
		rsp.hit    = slot_ok_s1 && (ram_rdata.epoch == epoch_s1);
		rsp.target = ram_rdata.target;
	end

	`SCSR_ASSERT_NEVER(a_no_req_in_sweep, clk, arst_n,
		clr_busy_q && (req.rd_en || req.wr_en || req.start))
	`SCSR_ASSERT_NEVER(a_epoch_live, clk, arst_n, epoch_q == scsr_pkg::EPOCH_NONE)
	`SCSR_ASSERT_NEXT(a_wrap_sweeps, clk, arst_n,
		!clr_busy_q && req.start && (epoch_q == scsr_pkg::EPOCH_MAX),
		clr_busy_q && (epoch_q == scsr_pkg::EPOCH_FIRST))

endmodule

@@ design/sparse_column_select_remap_unit.sv @@
// ----------------------------------------------------------------------------
// sparse_column_select_remap_unit
// Column-slice stage of a sparse row submatrix builder: loads a column map,
// keeps elements whose column is in the window and mapped, renames their
// column, and emits a saturating kept count at each row end.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    kind, old_column, new_position,
//                                     element_value
//  out      out  out_valid/out_ready  out_kind, new_column, out_value,
//                                     row_pointer
//  cfg      in   cfg_write            cfg_index, cfg_data
//
//  One word per cycle unless out stalls or a sweep runs; a result reaches out
//  through the map read register, then the output register.
//  The map RAM read port bounds the rate: one lookup per cycle.
//  After reset in_ready stays low while the map tags are swept; the same
//  sweep runs after every 255th start-job word.
//  A stalled out channel holds one result and one word in flight before
//  in_ready drops.
// ----------------------------------------------------------------------------
`include "sparse_column_select_remap_unit_assert.svh"

module sparse_column_select_remap_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] old_column,
	input  logic [15:0] new_position,
	input  logic [63:0] element_value,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [15:0] new_column,
	output logic [63:0] out_value,
	output logic [31:0] row_pointer
);

	logic [scsr_pkg::COL_W-1:0]   win_first_q;
	logic [scsr_pkg::COL_W-1:0]   win_last_q;

	logic                         accept;
	scsr_pkg::kind_t              in_kind;
	logic [scsr_pkg::COL_W-1:0]   offset;
	logic                         in_window;
	scsr_pkg::map_req_t           map_req;
	scsr_pkg::map_rsp_t           map_rsp;

	logic                         v_s1;
	scsr_pkg::kind_t              kind_s1;
	logic [scsr_pkg::VALUE_W-1:0] val_s1;
	logic                         s1_res;
	logic                         s1_go;

	logic [scsr_pkg::CNT_W-1:0]   count_q;

	logic                         out_v_q;
	logic                         out_kind_q;
	logic [scsr_pkg::POS_W-1:0]   out_col_q;
	logic [scsr_pkg::VALUE_W-1:0] out_val_q;
	logic [scsr_pkg::CNT_W-1:0]   out_ptr_q;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_first_q <= '0;
			win_last_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				scsr_pkg::REG_WINDOW_FIRST: win_first_q <= cfg_data;
				scsr_pkg::REG_WINDOW_LAST:  win_last_q  <= cfg_data;
			endcase
		end
	end

	// stage 0: window check and map slot
	always_comb begin
		accept    = in_valid && in_ready;
		in_kind   = scsr_pkg::kind_t'(kind);
		offset    = old_column - win_first_q;
		in_window = (old_column >= win_first_q) && (old_column <= win_last_q);

		map_req.rd_en   = accept && (in_kind == scsr_pkg::KIND_ELEM);
		map_req.wr_en   = accept && (in_kind == scsr_pkg::KIND_MAP);
		map_req.start   = accept && (in_kind == scsr_pkg::KIND_START);
		map_req.slot_ok = in_window && (offset < scsr_pkg::COL_W'(scsr_pkg::MAP_DEPTH));
		map_req.slot    = offset[scsr_pkg::ADDR_W-1:0];
		map_req.target  = new_position;
	end

	scsr_map u_map (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (map_req),
		.rsp   (map_rsp)
	);

	// stage 1 flow: moves unless its result finds the output register full and out stalled
	always_comb begin
		s1_res = v_s1 && (((kind_s1 == scsr_pkg::KIND_ELEM) && map_rsp.hit) ||
			(kind_s1 == scsr_pkg::KIND_ROW));
		s1_go    = v_s1 && (!s1_res || !out_v_q || out_ready);
		in_ready = !map_rsp.busy && (!v_s1 || s1_go);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= in_kind;
			val_s1  <= element_value[scsr_pkg::VALUE_W-1:0];
		end
	end

	// kept count, updated in word order at stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s1_go) begin
			if (kind_s1 == scsr_pkg::KIND_START) begin
				count_q <= '0;
			end else if ((kind_s1 == scsr_pkg::KIND_ELEM) && map_rsp.hit &&
				(count_q != scsr_pkg::COUNT_MAX)) begin
				count_q <= count_q + scsr_pkg::CNT_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_go && s1_res) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_res) begin
			if (kind_s1 == scsr_pkg::KIND_ROW) begin
				out_kind_q <= scsr_pkg::OUT_ROW;
				out_col_q  <= '0;
				out_val_q  <= '0;
				out_ptr_q  <= count_q;
			end else begin
				out_kind_q <= scsr_pkg::OUT_ELEM;
				out_col_q  <= map_rsp.target;
				out_val_q  <= val_s1;
				out_ptr_q  <= '0;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign out_kind    = out_kind_q;
	assign new_column  = out_col_q;
	assign out_value   = 64'(out_val_q);
	assign row_pointer = out_ptr_q;

	`SCSR_ASSERT_NEVER(a_no_accept_in_sweep, clk, arst_n, map_rsp.busy && in_ready)
	`SCSR_ASSERT_NEVER(a_s1_stall_needs_full_out, clk, arst_n, v_s1 && !s1_go && !out_v_q)
	`SCSR_ASSERT_NEXT(a_count_saturates, clk, arst_n,
		(count_q == scsr_pkg::COUNT_MAX) && !(s1_go && (kind_s1 == scsr_pkg::KIND_START)),
		count_q == scsr_pkg::COUNT_MAX)

endmodule
